/* src/srrw_pkg.sv */
package srrw_pkg;

	localparam int SEQ_W     = 32;
	localparam int LEN_W     = 11;
	localparam int TAG_W     = 16;
	localparam int KIND_W    = 2;
	localparam int WIN_W     = 6;
	localparam int ENTRY_W   = LEN_W + TAG_W;

	localparam int unsigned MAX_PAYLOAD = 1024;

	localparam logic [WIN_W-1:0] WIN_RST       = 6'd8;
	localparam logic [SEQ_W-1:0] START_NUM_RST = 32'd0;

	// register indexes
	localparam logic REG_WIN_SIZE  = 1'b0;
	localparam logic REG_START_NUM = 1'b1;

	// packet kinds
	localparam logic PKT_DATA = 1'b0;
	localparam logic PKT_END  = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] RES_DELIVER = 2'd0;
	localparam logic [KIND_W-1:0] RES_ACK     = 2'd1;
	localparam logic [KIND_W-1:0] RES_END     = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DRAIN
	} srrw_state_t;

	typedef struct packed {
		logic take_data;
		logic take_end;
		logic deliver;
		logic ack;
	} srrw_cmd_t;

	typedef struct packed {
		logic head_valid;
	} srrw_status_t;

endpackage

/* src/srrw_ram.sv */
module srrw_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/srrw_ctrl.sv */
module srrw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  pkt_kind,
	input  srrw_pkg::srrw_status_t status,
	output srrw_pkg::srrw_cmd_t    cmd,
	output logic                  busy
);

	srrw_pkg::srrw_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srrw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			srrw_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (pkt_kind == srrw_pkg::PKT_END) begin
						// single end beat, ready again next cycle
						cmd.take_end = 1'b1;
					end else begin
						cmd.take_data = 1'b1;
						state_d       = srrw_pkg::ST_CHECK;
					end
				end
			end
			// slot RAM read of the head entry lands here
			srrw_pkg::ST_CHECK: begin
				state_d = srrw_pkg::ST_DRAIN;
			end
			srrw_pkg::ST_DRAIN: begin
				if (status.head_valid) begin
					cmd.deliver = 1'b1;
				end else begin
					cmd.ack = 1'b1;
					state_d = srrw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srrw_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* src/srrw_datapath.sv */
module srrw_datapath #(
	parameter int WINDOW_SLOTS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  srrw_pkg::srrw_cmd_t                   cmd,
	output srrw_pkg::srrw_status_t                status,
	input  logic [srrw_pkg::WIN_W-1:0]            win_size,
	input  logic [srrw_pkg::SEQ_W-1:0]            start_num,
	input  logic [srrw_pkg::SEQ_W-1:0]            pkt_seq,
	input  logic [srrw_pkg::LEN_W-1:0]            pkt_len,
	input  logic [srrw_pkg::TAG_W-1:0]            pkt_tag,
	output logic                                  result_valid,
	output logic [srrw_pkg::KIND_W-1:0]           result_kind,
	output logic [srrw_pkg::SEQ_W-1:0]            out_seq,
	output logic [srrw_pkg::LEN_W-1:0]            out_len,
	output logic [srrw_pkg::TAG_W-1:0]            out_tag,
	output logic [srrw_pkg::SEQ_W-1:0]            ack_seq,
	output logic                                  last_of_run
);

	localparam int SW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	// slot count must be a power of two, which the block does not check; the slot is the masked low sequence bits
	localparam logic [SW-1:0]                 SLOT_MASK = SW'(WINDOW_SLOTS - 1);
	localparam logic [srrw_pkg::WIN_W-1:0]    SLOTS_W = srrw_pkg::WIN_W'(WINDOW_SLOTS);
	localparam int                            LCMP_W  = 17;

	logic [srrw_pkg::SEQ_W-1:0]     exp_q;
	logic [WINDOW_SLOTS-1:0]        valid_q;

	logic [srrw_pkg::WIN_W-1:0]     win_eff;
	logic [srrw_pkg::SEQ_W-1:0]     off;
	logic                           in_win;
	logic                           len_ok;
	logic                           store;
	logic [srrw_pkg::SEQ_W-1:0]     exp_inc;
	logic [SW-1:0]                  pkt_slot;
	logic [SW-1:0]                  head_slot;
	logic [SW-1:0]                  next_slot;
	logic [SW-1:0]                  raddr;
	logic [srrw_pkg::ENTRY_W-1:0]   rdata;
	logic [srrw_pkg::ENTRY_W-1:0]   wdata;

	// window and length checks with wrap-safe offset, slot addresses and RAM write data
	always_comb begin
		win_eff   = (win_size > SLOTS_W) ? SLOTS_W : win_size;
		off       = pkt_seq - exp_q;
		in_win    = (off[srrw_pkg::SEQ_W-1:srrw_pkg::WIN_W] == '0) &&
		            (off[srrw_pkg::WIN_W-1:0] < win_eff);
		len_ok    = (LCMP_W'(pkt_len) <= LCMP_W'(srrw_pkg::MAX_PAYLOAD));
		store     = cmd.take_data && in_win && len_ok;
		pkt_slot  = pkt_seq[SW-1:0] & SLOT_MASK;
		head_slot = exp_q[SW-1:0] & SLOT_MASK;
		exp_inc   = exp_q + srrw_pkg::SEQ_W'(1);
		next_slot = exp_inc[SW-1:0] & SLOT_MASK;
		raddr     = cmd.deliver ? next_slot : head_slot;
		wdata     = {pkt_tag, pkt_len};
	end

	assign status.head_valid = valid_q[head_slot];

	srrw_ram #(
		.WIDTH (srrw_pkg::ENTRY_W),
		.DEPTH (WINDOW_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (store),
		.waddr (pkt_slot),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q        <= srrw_pkg::START_NUM_RST;
			valid_q      <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.take_end || cmd.deliver || cmd.ack;
			if (cmd.take_end) begin
				exp_q   <= start_num;
				valid_q <= '0;
			end else begin
				if (store) begin
					valid_q[pkt_slot] <= 1'b1;
				end
				if (cmd.deliver) begin
					valid_q[head_slot] <= 1'b0;
					exp_q              <= exp_inc;
				end
			end
		end
	end

	// result beat registers
	always_ff @(posedge clk) begin
		if (cmd.take_end || cmd.deliver || cmd.ack) begin
			result_kind <= srrw_pkg::RES_END;
			out_seq     <= '0;
			out_len     <= '0;
			out_tag     <= '0;
			ack_seq     <= '0;
			last_of_run <= 1'b1;
			if (cmd.deliver) begin
				result_kind <= srrw_pkg::RES_DELIVER;
				out_seq     <= exp_q;
				out_len     <= rdata[srrw_pkg::LEN_W-1:0];
				out_tag     <= rdata[srrw_pkg::ENTRY_W-1:srrw_pkg::LEN_W];
				last_of_run <= 1'b0;
			end else if (cmd.ack) begin
				result_kind <= srrw_pkg::RES_ACK;
				ack_seq     <= exp_q;
			end
		end
	end

endmodule

/* src/selective_repeat_receive_window.sv */
// Data packet: busy from the accepting edge through the check and drain states; one
// beat per cycle, a delivery per valid head slot, then the ack; first beat shows after
// the first drain state. Deliveries read the slot RAM through its single read port.
// End packet: end beat the cycle after accept; the next packet can be taken at the
// following edge. Results cannot be stalled.
// Reset: window width 8, start number 0, expected 0, all slots invalid.
module selective_repeat_receive_window #(
	parameter int WINDOW_SLOTS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               start,
	output logic                               busy,
	input  logic                               pkt_kind,
	input  logic [srrw_pkg::SEQ_W-1:0]         pkt_seq,
	input  logic [srrw_pkg::LEN_W-1:0]         pkt_len,
	input  logic [srrw_pkg::TAG_W-1:0]         pkt_tag,
	output logic                               result_valid,
	output logic [srrw_pkg::KIND_W-1:0]        result_kind,
	output logic [srrw_pkg::SEQ_W-1:0]         out_seq,
	output logic [srrw_pkg::LEN_W-1:0]         out_len,
	output logic [srrw_pkg::TAG_W-1:0]         out_tag,
	output logic [srrw_pkg::SEQ_W-1:0]         ack_seq,
	output logic                               last_of_run
);

	logic [srrw_pkg::WIN_W-1:0] win_size_q;
	logic [srrw_pkg::SEQ_W-1:0] start_num_q;
	logic                       reg_wr;
	logic                       reg_idx;

	srrw_pkg::srrw_cmd_t    cmd;
	srrw_pkg::srrw_status_t status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q  <= srrw_pkg::WIN_RST;
			start_num_q <= srrw_pkg::START_NUM_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				srrw_pkg::REG_WIN_SIZE:  win_size_q  <= pwdata[srrw_pkg::WIN_W-1:0];
				srrw_pkg::REG_START_NUM: start_num_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			srrw_pkg::REG_WIN_SIZE:  prdata = 32'(win_size_q);
			srrw_pkg::REG_START_NUM: prdata = start_num_q;
			default:                 prdata = '0;
		endcase
	end

	srrw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.pkt_kind (pkt_kind),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	srrw_datapath #(
		.WINDOW_SLOTS (WINDOW_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.win_size     (win_size_q),
		.start_num    (start_num_q),
		.pkt_seq      (pkt_seq),
		.pkt_len      (pkt_len),
		.pkt_tag      (pkt_tag),
		.result_valid (result_valid),
		.result_kind  (result_kind),
		.out_seq      (out_seq),
		.out_len      (out_len),
		.out_tag      (out_tag),
		.ack_seq      (ack_seq),
		.last_of_run  (last_of_run)
	);

endmodule

/* tb/sv/selective_repeat_receive_window_test.sv */
`timescale 1ns / 100ps

module selective_repeat_receive_window_test;

	localparam int SLOTS       = 8;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 46;
	localparam int GAP_MAX     = 12;

	typedef logic [srrw_pkg::KIND_W-1:0] kind_t;
	typedef logic [srrw_pkg::SEQ_W-1:0]  seq_t;
	typedef logic [srrw_pkg::LEN_W-1:0]  len_t;
	typedef logic [srrw_pkg::TAG_W-1:0]  tag_t;

	typedef struct {
		kind_t kind;
		seq_t  seq;
		len_t  len;
		tag_t  tag;
		seq_t  ack;
		logic  last;
	} window_beat_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [2:0]        paddr   = '0;
	logic [31:0]       pwdata  = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              start    = 1'b0;
	logic              busy;
	logic              pkt_kind = srrw_pkg::PKT_DATA;
	seq_t              pkt_seq  = '0;
	len_t              pkt_len  = '0;
	tag_t              pkt_tag  = '0;
	logic              result_valid;
	kind_t             result_kind;
	seq_t              out_seq;
	len_t              out_len;
	tag_t              out_tag;
	seq_t              ack_seq;
	logic              last_of_run;

	// receiver state as the testbench sees it
	logic [srrw_pkg::WIN_W-1:0] win_reg = srrw_pkg::WIN_RST;
	seq_t              start_reg = srrw_pkg::START_NUM_RST;
	seq_t              next_seq  = srrw_pkg::START_NUM_RST;
	logic [SLOTS-1:0]  slot_full = '0;
	len_t              slot_len [SLOTS];
	tag_t              slot_tag [SLOTS];

	window_beat_t pending_beats[$];

	int errors          = 0;
	int packets_sent    = 0;
	int beats_checked   = 0;
	int deliveries      = 0;
	int settings_tried  = 0;
	int cycles          = 0;

	always #10 clk = ~clk;

	selective_repeat_receive_window #(
		.WINDOW_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.pkt_kind(pkt_kind),
		.pkt_seq(pkt_seq),
		.pkt_len(pkt_len),
		.pkt_tag(pkt_tag),
		.result_valid(result_valid),
		.result_kind(result_kind),
		.out_seq(out_seq),
		.out_len(out_len),
		.out_tag(out_tag),
		.ack_seq(ack_seq),
		.last_of_run(last_of_run)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats pending", cycles, pending_beats.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= 40)
			$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	function automatic window_beat_t make_beat(input kind_t kind, input seq_t seq,
			input len_t len, input tag_t tag, input seq_t ack, input logic last);
		window_beat_t b;
		b.kind = kind;
		b.seq  = seq;
		b.len  = len;
		b.tag  = tag;
		b.ack  = ack;
		b.last = last;
		return b;
	endfunction

	task automatic expect_beat(input window_beat_t b);
		pending_beats.insert(pending_beats.size(), b);
	endtask

	task automatic predict_packet(input logic kind, input seq_t seq, input len_t len,
			input tag_t tag);
		seq_t offset;
		seq_t eff_win;
		int   n;
		if (kind == srrw_pkg::PKT_END) begin
			expect_beat(make_beat(srrw_pkg::RES_END, '0, '0, '0, '0, 1'b1));
			next_seq  = start_reg;
			slot_full = '0;
		end else begin
			eff_win = (win_reg > SLOTS) ? seq_t'(SLOTS) : seq_t'(win_reg);
			// unsigned difference keeps the window test safe across wrap
			offset = seq - next_seq;
			if (offset < eff_win && len <= srrw_pkg::MAX_PAYLOAD) begin
				slot_len[seq[SLOT_W-1:0]]  = len;
				slot_tag[seq[SLOT_W-1:0]]  = tag;
				slot_full[seq[SLOT_W-1:0]] = 1'b1;
				n = 0;
				while (n < SLOTS && slot_full[next_seq[SLOT_W-1:0]]) begin
					expect_beat(make_beat(srrw_pkg::RES_DELIVER, next_seq,
						slot_len[next_seq[SLOT_W-1:0]], slot_tag[next_seq[SLOT_W-1:0]],
						'0, 1'b0));
					slot_full[next_seq[SLOT_W-1:0]] = 1'b0;
					next_seq = next_seq + seq_t'(1);
					deliveries++;
					n++;
				end
			end
			expect_beat(make_beat(srrw_pkg::RES_ACK, '0, '0, '0, next_seq, 1'b1));
		end
	endtask

	// start stays high across back-to-back packets; in this task it only drops for a gap
	task automatic issue_packet(input logic kind, input seq_t seq, input len_t len,
			input tag_t tag);
		int gap;
		gap = $urandom_range(GAP_MAX, 0);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		pkt_kind <= kind;
		pkt_seq  <= seq;
		pkt_len  <= len;
		pkt_tag  <= tag;
		do @(posedge clk); while (busy);
		predict_packet(kind, seq, len, tag);
		packets_sent++;
	endtask

	task automatic send_data(input seq_t seq, input len_t len, input tag_t tag);
		issue_packet(srrw_pkg::PKT_DATA, seq, len, tag);
	endtask

	task automatic send_end();
		issue_packet(srrw_pkg::PKT_END, $urandom, len_t'($urandom_range(2047, 0)),
			tag_t'($urandom));
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		// a data packet stays busy until its ack beat is out
		while (busy) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == srrw_pkg::REG_WIN_SIZE)
			win_reg = value[srrw_pkg::WIN_W-1:0];
		else
			start_reg = value;
		settings_tried++;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		window_beat_t want;
		if (arst_n && result_valid) begin
			beats_checked++;
			if (pending_beats.size() == 0) begin
				report_mismatch("beat with nothing pending, kind", 32'(result_kind), '0);
			end else begin
				want = pending_beats.pop_front();
				if (result_kind !== want.kind)
					report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
				if (out_seq !== want.seq)
					report_mismatch("out_seq", out_seq, want.seq);
				if (out_len !== want.len)
					report_mismatch("out_len", 32'(out_len), 32'(want.len));
				if (out_tag !== want.tag)
					report_mismatch("out_tag", 32'(out_tag), 32'(want.tag));
				if (ack_seq !== want.ack)
					report_mismatch("ack_seq", ack_seq, want.ack);
				if (last_of_run !== want.last)
					report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last));
			end
		end
	end

	task automatic test_in_order();
		send_data(next_seq, 11'd0, 16'h0000);
		send_data(next_seq, 11'd1024, 16'hFFFF);
		send_data(next_seq, 11'd7, 16'h1234);
	endtask

	// fill the window back to front, then the head releases all eight
	task automatic test_full_window_drain();
		seq_t base;
		base = next_seq;
		for (int i = SLOTS - 1; i >= 1; i--) begin
			send_data(base + seq_t'(i), len_t'($urandom_range(1024, 0)), tag_t'($urandom));
			if (i == 3)
				send_data(base + seq_t'(i), len_t'($urandom_range(1024, 0)),
					tag_t'($urandom));
		end
		send_data(base, len_t'($urandom_range(1024, 0)), tag_t'($urandom));
	endtask

	task automatic test_payload_limit();
		send_data(next_seq, 11'd1025, tag_t'($urandom));
		send_data(next_seq, 11'd2047, tag_t'($urandom));
		send_data(next_seq, 11'd1024, tag_t'($urandom));
	endtask

	task automatic test_window_edges();
		send_data(next_seq + seq_t'(SLOTS), 11'd10, tag_t'($urandom));
		send_data(next_seq - seq_t'(1), 11'd10, tag_t'($urandom));
		wait_idle();
		reg_write(srrw_pkg::REG_WIN_SIZE, 32'd0);
		send_data(next_seq, 11'd10, tag_t'($urandom));
		wait_idle();
		// above the slot count, saturates to eight
		reg_write(srrw_pkg::REG_WIN_SIZE, 32'd63);
		send_data(next_seq + seq_t'(SLOTS - 1), len_t'($urandom_range(1024, 0)),
			tag_t'($urandom));
		send_data(next_seq, len_t'($urandom_range(1024, 0)), tag_t'($urandom));
		wait_idle();
		reg_write(srrw_pkg::REG_WIN_SIZE, 32'd1);
		send_data(next_seq + seq_t'(1), 11'd3, tag_t'($urandom));
		send_data(next_seq, 11'd3, tag_t'($urandom));
	endtask

	task automatic test_start_number();
		wait_idle();
		reg_write(srrw_pkg::REG_WIN_SIZE, 32'd8);
		reg_write(srrw_pkg::REG_START_NUM, 32'hFFFF_FFFE);
		// new start number is not live until the end packet
		send_data(next_seq, 11'd5, tag_t'($urandom));
		send_end();
		send_data(32'hFFFF_FFFF, 11'd9, tag_t'($urandom));
		send_data(32'hFFFF_FFFE, 11'd8, tag_t'($urandom));
	endtask

	task automatic test_random();
		int   r;
		seq_t eff_win;
		seq_t seq;
		len_t len;
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: reg_write(srrw_pkg::REG_WIN_SIZE, 32'd8);
				1: reg_write(srrw_pkg::REG_WIN_SIZE, 32'd63);
				2: reg_write(srrw_pkg::REG_WIN_SIZE, $urandom_range(63, 1));
				3: reg_write(srrw_pkg::REG_WIN_SIZE, 32'd2);
				default: reg_write(srrw_pkg::REG_WIN_SIZE, $urandom_range(63, 0));
			endcase
			if (phase % 2)
				reg_write(srrw_pkg::REG_START_NUM, 32'hFFFF_FFF0 + $urandom_range(15, 0));
			else
				reg_write(srrw_pkg::REG_START_NUM, $urandom);
			send_end();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase == 2 && i == PHASE_ITEMS / 2) begin
					start <= 1'b0;
					while (pending_beats.size() != 0) @(posedge clk);
				end
				r = $urandom_range(99, 0);
				eff_win = (win_reg > SLOTS) ? seq_t'(SLOTS) : seq_t'(win_reg);
				if (r < 6) begin
					send_end();
				end else if (r < 14) begin
					send_data($urandom, len_t'($urandom_range(2047, 0)), tag_t'($urandom));
				end else begin
					// mostly in window, one past the edge now and then
					seq = next_seq + $urandom_range(eff_win, 0);
					if ($urandom_range(29, 0) == 0)
						len = len_t'($urandom_range(2047, 1025));
					else
						len = len_t'($urandom_range(1024, 0));
					send_data(seq, len, tag_t'($urandom));
				end
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_in_order();
		test_full_window_drain();
		test_payload_limit();
		test_window_edges();
		test_start_number();
		test_random();
		wait_idle();
		repeat (40) @(posedge clk);
		if (pending_beats.size() != 0)
			report_mismatch("beats never delivered", 32'(pending_beats.size()), '0);
		$display("%0d packets over %0d register writes; %0d beats checked, %0d in-order deliveries",
			packets_sent, settings_tried, beats_checked, deliveries);
		$display("windows 0, 1, 2, 8, 63 and random; start numbers near wrap and random");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* selective_repeat_receive_window.f */
src/srrw_pkg.sv
src/srrw_ram.sv
src/srrw_ctrl.sv
src/srrw_datapath.sv
src/selective_repeat_receive_window.sv
tb/sv/selective_repeat_receive_window_test.sv
